// File: rtl/bdpt_pkg.sv
// bdpt_pkg: item types, state codes and constants for the button debounce press timer
// no dependencies

package bdpt_pkg;

  localparam int unsigned TICK_W = 32;
  localparam int unsigned CNT_W  = 8;

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd40;

  // encoded button state as seen on the result item
  localparam logic [1:0] BS_UP      = 2'd0;
  localparam logic [1:0] BS_FALLING = 2'd1;
  localparam logic [1:0] BS_DOWN    = 2'd2;
  localparam logic [1:0] BS_RISING  = 2'd3;

  typedef enum logic [3:0] {
    ST_UP      = 4'b0001,
    ST_FALLING = 4'b0010,
    ST_DOWN    = 4'b0100,
    ST_RISING  = 4'b1000
  } bdpt_state_t;

  typedef struct packed {
    logic              key_level;
    logic [TICK_W-1:0] now_ticks;
  } bdpt_in_t;

  typedef struct packed {
    logic [1:0]        button_state;
    logic [TICK_W-1:0] press_duration;
    logic              release_confirmed;
  } bdpt_out_t;

endpackage

// File: rtl/bdpt_fsm.sv
// bdpt_fsm: four-state debounce machine with wait counter and press timestamp
// depends on bdpt_pkg

module bdpt_fsm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  bdpt_pkg::bdpt_in_t          item,
  input  logic [bdpt_pkg::CNT_W-1:0]  debounce_count,
  output bdpt_pkg::bdpt_out_t         result
);

  bdpt_pkg::bdpt_state_t              state_r, state_nxt;
  logic [bdpt_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [bdpt_pkg::TICK_W-1:0]        press_time_r, press_time_nxt;
  logic [bdpt_pkg::TICK_W-1:0]        held_r, held_nxt;
  logic                               released;
  logic                               pressed;
  logic                               wait_done;

  assign pressed   = ~item.key_level;
  assign wait_done = (cnt_r >= debounce_count);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    press_time_nxt = press_time_r;
    held_nxt       = held_r;
    released       = 1'b0;
    case (state_r)
      bdpt_pkg::ST_UP: begin
        held_nxt = '0;
        if (pressed) begin
          state_nxt = bdpt_pkg::ST_FALLING;
        end
      end
      bdpt_pkg::ST_FALLING: begin
        if (wait_done) begin
          cnt_nxt = '0;
          if (pressed) begin
            state_nxt      = bdpt_pkg::ST_DOWN;
            press_time_nxt = item.now_ticks;
          end else begin
            state_nxt = bdpt_pkg::ST_UP;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      bdpt_pkg::ST_DOWN: begin
        if (!pressed) begin
          state_nxt = bdpt_pkg::ST_RISING;
        end
      end
      bdpt_pkg::ST_RISING: begin
        if (wait_done) begin
          cnt_nxt = '0;
          if (!pressed) begin
            state_nxt = bdpt_pkg::ST_UP;
            held_nxt  = item.now_ticks - press_time_r;
            released  = 1'b1;
          end else begin
            state_nxt = bdpt_pkg::ST_DOWN;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = bdpt_pkg::ST_UP;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    case (state_nxt)
      bdpt_pkg::ST_UP:      result.button_state = bdpt_pkg::BS_UP;
      bdpt_pkg::ST_FALLING: result.button_state = bdpt_pkg::BS_FALLING;
      bdpt_pkg::ST_DOWN:    result.button_state = bdpt_pkg::BS_DOWN;
      bdpt_pkg::ST_RISING:  result.button_state = bdpt_pkg::BS_RISING;
      default:              result.button_state = bdpt_pkg::BS_UP;
    endcase
    result.press_duration    = held_nxt;
    result.release_confirmed = released;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bdpt_pkg::ST_UP;
      cnt_r        <= '0;
      press_time_r <= '0;
      held_r       <= '0;
    end else if (step) begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      press_time_r <= press_time_nxt;
      held_r       <= held_nxt;
    end
  end

endmodule

// File: rtl/button_debounce_press_timer_top.sv
// button_debounce_press_timer_top: input register, debounce machine, result register
// depends on bdpt_pkg and bdpt_fsm
//
//   channel | ports                                  | direction
//   in      | in_valid, in_stall, in_data            | item in, stall out
//   out     | out_valid, out_stall, out_data         | item out, stall in
//   cfg     | cfg_wr_en, cfg_wr_data                 | debounce count write
//
// one item per cycle sustained while out_stall is low; an accepted item passes through the
// input register, then the state update into the result register
// the result register frees the input side while a finished item waits for the sink
// rst_n is synchronous: machine in up, timers zero, debounce count 40, both stages empty
// out_stall holds the result register and, once the input register is full, raises in_stall

module button_debounce_press_timer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bdpt_pkg::bdpt_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bdpt_pkg::bdpt_out_t         out_data,
  input  logic                        cfg_wr_en,
  input  logic [bdpt_pkg::CNT_W-1:0]  cfg_wr_data
);

  logic                        s1_valid_r;
  bdpt_pkg::bdpt_in_t          s1_data_r;
  logic                        out_valid_r;
  bdpt_pkg::bdpt_out_t         out_data_r;
  logic [bdpt_pkg::CNT_W-1:0]  debounce_count_r;
  bdpt_pkg::bdpt_out_t         fsm_result;
  logic                        out_ready;
  logic                        advance;
  logic                        in_take;

  assign out_ready = ~out_valid_r | ~out_stall;
  assign advance   = s1_valid_r & out_ready;
  assign in_stall  = s1_valid_r & ~out_ready;
  assign in_take   = in_valid & ~in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_count_r <= bdpt_pkg::DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      debounce_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
  end

  bdpt_fsm u_fsm (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .item           (s1_data_r),
    .debounce_count (debounce_count_r),
    .result         (fsm_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= fsm_result;
    end
  end

`ifndef SYNTHESIS
  a_release_in_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.release_confirmed |-> out_data_r.button_state == bdpt_pkg::BS_UP)
    else $error("release confirmed outside up state");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced item missing from result register");

  a_blocked_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_ready |=> s1_valid_r && $stable(s1_data_r))
    else $error("input register changed while blocked");

  a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_ready |-> !in_take)
    else $error("item taken while input register blocked");
`endif

endmodule

// File: tb/tb_button_debounce_press_timer_top.sv
`timescale 1ns / 100ps
// tb_button_debounce_press_timer_top: self-checking bench for the debounce press timer,
// with directed and random key sequences under several debounce counts and stall mixes
// depends on bdpt_pkg and button_debounce_press_timer_top

module tb_button_debounce_press_timer_top;

  class press_timer_scoreboard;
    logic [bdpt_pkg::CNT_W-1:0]  debounce_count;
    logic [1:0]                  key_phase;
    logic [bdpt_pkg::CNT_W-1:0]  fall_wait;
    logic [bdpt_pkg::CNT_W-1:0]  rise_wait;
    logic [bdpt_pkg::TICK_W-1:0] press_stamp;
    logic [bdpt_pkg::TICK_W-1:0] held_ticks;
    bdpt_pkg::bdpt_out_t         predicted_reports[$];
    int unsigned                 mismatches;

    function new();
      debounce_count = bdpt_pkg::DEBOUNCE_RESET;
      key_phase = bdpt_pkg::BS_UP;
      fall_wait = '0;
      rise_wait = '0;
      press_stamp = '0;
      held_ticks = '0;
      mismatches = 0;
    endfunction

    function void note_input(bdpt_pkg::bdpt_in_t item);
      bdpt_pkg::bdpt_out_t report;
      logic                pressed;
      pressed = ~item.key_level;
      report.release_confirmed = 1'b0;
      case (key_phase)
        bdpt_pkg::BS_UP: begin
          held_ticks = '0;
          if (pressed) key_phase = bdpt_pkg::BS_FALLING;
        end
        bdpt_pkg::BS_FALLING: begin
          if (fall_wait >= debounce_count) begin
            if (pressed) begin
              key_phase = bdpt_pkg::BS_DOWN;
              press_stamp = item.now_ticks;
            end else begin
              key_phase = bdpt_pkg::BS_UP;
            end
            fall_wait = '0;
          end else begin
            fall_wait = fall_wait + 1'b1;
          end
        end
        bdpt_pkg::BS_DOWN: begin
          if (!pressed) key_phase = bdpt_pkg::BS_RISING;
        end
        default: begin
          if (rise_wait >= debounce_count) begin
            if (!pressed) begin
              key_phase = bdpt_pkg::BS_UP;
              held_ticks = item.now_ticks - press_stamp;
              report.release_confirmed = 1'b1;
            end else begin
              key_phase = bdpt_pkg::BS_DOWN;
            end
            rise_wait = '0;
          end else begin
            rise_wait = rise_wait + 1'b1;
          end
        end
      endcase
      report.button_state = key_phase;
      report.press_duration = held_ticks;
      predicted_reports.push_back(report);
    endfunction

    function void check_result(bdpt_pkg::bdpt_out_t got);
      bdpt_pkg::bdpt_out_t want;
      if (predicted_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: state %0d duration %h release %0b",
                   got.button_state, got.press_duration, got.release_confirmed);
        return;
      end
      want = predicted_reports.pop_front();
      if (got.button_state !== want.button_state ||
          got.press_duration !== want.press_duration ||
          got.release_confirmed !== want.release_confirmed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected state %0d duration %h release %0b, got %0d %h %0b",
                   want.button_state, want.press_duration, want.release_confirmed,
                   got.button_state, got.press_duration, got.release_confirmed);
      end
    endfunction

    function int pending();
      return predicted_reports.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  bdpt_pkg::bdpt_in_t            in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  bdpt_pkg::bdpt_out_t           out_data;
  logic                          cfg_wr_en = 1'b0;
  logic [bdpt_pkg::CNT_W-1:0]    cfg_wr_data = '0;

  press_timer_scoreboard         board = new();
  logic [bdpt_pkg::TICK_W-1:0]   tick_now = '0;
  int                            src_idle_pct = 0;
  int                            sink_stall_pct = 0;

  button_debounce_press_timer_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_input(in_data);
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  task automatic send_item(input logic level, input logic [bdpt_pkg::TICK_W-1:0] ticks);
    bdpt_pkg::bdpt_in_t item;
    item.key_level = level;
    item.now_ticks = ticks;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_key(input logic level);
    if ($urandom_range(99) < 4) tick_now = $urandom();
    else tick_now = tick_now + $urandom_range(1, 64);
    send_item(level, tick_now);
  endtask

  // drain the block before touching the debounce count
  task automatic program_count(input logic [bdpt_pkg::CNT_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.debounce_count = value;
  endtask

  // runs of steady key level, mostly long enough to confirm, with bounces and noise
  task automatic run_phase(input int count, input int n_items);
    int   sent;
    int   len;
    int   kind;
    logic level;
    program_count(bdpt_pkg::CNT_W'(count));
    sent = 0;
    level = 1'b0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 65) len = count + 2 + $urandom_range(0, 3);
      else if (kind < 90) len = $urandom_range(1, count + 1);
      else len = $urandom_range(1, 4);
      for (int k = 0; k < len && sent < n_items; k++) begin
        send_key(kind < 90 ? level : 1'($urandom_range(0, 1)));
        sent++;
      end
      if (kind < 90) level = ~level;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    src_idle_pct = 29;
    sink_stall_pct = 50;

    // reset count of 40, idle key at tick extremes, then a press cut short
    send_item(1'b1, 32'h0000_0000);
    send_item(1'b1, 32'hFFFF_FFFF);
    tick_now = 32'h0000_0100;
    repeat (5) send_key(1'b0);
    // count lowered mid wait: next item decides, key released so back to up
    program_count(8'd2);
    send_key(1'b1);
    send_item(1'b0, 32'hFFFF_FFF0);
    send_item(1'b0, 32'hFFFF_FFF2);
    send_item(1'b0, 32'hFFFF_FFF4);
    send_item(1'b0, 32'hFFFF_FFF8);
    // release that bounces back to down
    send_item(1'b1, 32'hFFFF_FFFA);
    send_item(1'b1, 32'hFFFF_FFFC);
    send_item(1'b1, 32'hFFFF_FFFE);
    send_item(1'b0, 32'h0000_0000);
    // confirmed release across the tick wrap, then duration cleared in up
    send_item(1'b1, 32'h0000_0002);
    send_item(1'b1, 32'h0000_0004);
    send_item(1'b1, 32'h0000_0006);
    send_item(1'b1, 32'h0000_0010);
    send_item(1'b1, 32'h0000_0012);
    // zero count decides on the first waiting item
    program_count(8'd0);
    send_item(1'b0, 32'h8000_0000);
    send_item(1'b0, 32'h8000_0001);
    send_item(1'b1, 32'h8000_0002);
    send_item(1'b1, 32'h7FFF_FFFF);
    tick_now = 32'h7FFF_FFFF;

    run_phase(1, 80);
    run_phase(3, 80);

    src_idle_pct = 50;
    sink_stall_pct = 29;
    run_phase(255, 530);

    src_idle_pct = 0;
    sink_stall_pct = 0;
    run_phase(0, 80);
    run_phase($urandom_range(4, 9), 80);
    run_phase(2, 80);

    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
